// ===== src/sin_pkg.sv =====
// ----------------------------------------------------------------------------
// sin_pkg
// Shared types and constants for the slice index normalizer.
// ----------------------------------------------------------------------------
package sin_pkg;

  localparam int IndexWidth = 32;

  typedef struct packed {
    logic [IndexWidth-2:0] seq_length;
    logic signed [IndexWidth-1:0] start_index;
    logic start_given;
    logic signed [IndexWidth-1:0] stop_index;
    logic stop_given;
    logic signed [IndexWidth-1:0] step_value;
    logic step_given;
  } in_beat_t;

  typedef struct packed {
    logic signed [IndexWidth-1:0] norm_start;
    logic signed [IndexWidth-1:0] norm_stop;
    logic signed [IndexWidth-1:0] norm_step;
    logic [IndexWidth-2:0] element_count;
    logic zero_step_error;
  } out_beat_t;

endpackage

// ===== src/sin_bounds.sv =====
// ----------------------------------------------------------------------------
// sin_bounds
// Two-stage bound placement: wrap negative indices, then clamp and default.
// ----------------------------------------------------------------------------
module sin_bounds #(
  parameter int W = sin_pkg::IndexWidth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [W-2:0]        len,
  input  logic signed [W-1:0] a_idx,
  input  logic                a_given,
  input  logic signed [W-1:0] b_idx,
  input  logic                b_given,
  input  logic signed [W-1:0] step,
  output logic                out_vld,
  output logic signed [W+1:0] first,
  output logic signed [W+1:0] last,
  output logic signed [W-1:0] step_o
);

  logic                vld1_r, vld2_r;
  logic signed [W+1:0] wa_r, wb_r, lo_r, hi_r;
  logic                ag_r, bg_r, fwd_r;
  logic signed [W-1:0] st1_r, st2_r;
  logic signed [W+1:0] fa_r, fb_r;
  logic signed [W+1:0] el, fa_nxt, fb_nxt, ca, cb;
  logic                fwd;

  assign el  = {3'b000, len};
  assign fwd = step > 0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    wa_r   <= (W+2)'(a_idx) + ((a_idx < 0) ? el : '0);
    wb_r   <= (W+2)'(b_idx) + ((b_idx < 0) ? el : '0);
    lo_r   <= fwd ? '0 : -(W+2)'(1);
    hi_r   <= fwd ? el : el - (W+2)'(1);
    ag_r   <= a_given;
    bg_r   <= b_given;
    fwd_r  <= fwd;
    st1_r  <= step;
  end

  always_comb begin
    ca = (wa_r < lo_r) ? lo_r : ((wa_r > hi_r) ? hi_r : wa_r);
    cb = (wb_r < lo_r) ? lo_r : ((wb_r > hi_r) ? hi_r : wb_r);
    fa_nxt = ag_r ? ca : (fwd_r ? lo_r : hi_r);
    fb_nxt = bg_r ? cb : (fwd_r ? hi_r : lo_r);
  end

  always_ff @(posedge clk) begin
    fa_r   <= fa_nxt;
    fb_r   <= fb_nxt;
    st2_r  <= st1_r;
  end

  assign out_vld = vld2_r;
  assign first   = fa_r;
  assign last    = fb_r;
  assign step_o  = st2_r;

endmodule

// ===== src/sin_divider.sv =====
// ----------------------------------------------------------------------------
// sin_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sin_divider #(
  parameter int W = sin_pkg::IndexWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [W-1:0]           dividend,
  input  logic [W-1:0]           divisor,
  input  logic                   nonempty,
  input  sin_pkg::out_beat_t     side,
  output logic                   out_vld,
  output sin_pkg::out_beat_t     result
);

  logic               vld_r  [W+1];
  logic [W-1:0]       rem_r  [W+1];
  logic [W-1:0]       quo_r  [W+1];
  logic [W-1:0]       div_r  [W+1];
  logic               ne_r   [W+1];
  sin_pkg::out_beat_t side_r [W+1];

  assign rem_r[0]  = '0;
  assign quo_r[0]  = dividend;
  assign div_r[0]  = divisor;
  assign ne_r[0]   = nonempty;
  assign side_r[0] = side;
  assign vld_r[0]  = in_vld;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0]   sh;
    logic [W:0]   df;
    logic         ge;
    logic [W-1:0] rem_nxt, quo_nxt;
    assign sh = {rem_r[i], quo_r[i][W-1]};
    assign df = sh - {1'b0, div_r[i]};
    assign ge = !df[W];
    assign rem_nxt = ge ? df[W-1:0] : sh[W-1:0];
    assign quo_nxt = {quo_r[i][W-2:0], ge};
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= rem_nxt;
      quo_r[i+1]  <= quo_nxt;
      div_r[i+1]  <= div_r[i];
      ne_r[i+1]   <= ne_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  always_comb begin
    result = side_r[W];
    result.element_count = ne_r[W] ? (W-1)'(quo_r[W] + W'(1)) : '0;
  end
  assign out_vld = vld_r[W];

endmodule

// ===== src/slice_index_normalizer.sv =====
// ----------------------------------------------------------------------------
// slice_index_normalizer
// Normalizes slice start/stop/step and counts the selected elements.
// ----------------------------------------------------------------------------
// One request enters per cycle whenever start is high; busy is always low.
// Each result passes through a two-stage bound placement, one span stage
// and a W-stage pipelined divider.
// out_valid pulses for one cycle; the receiver must take it then.
module slice_index_normalizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sin_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output sin_pkg::out_beat_t out_beat
);

  localparam int W = sin_pkg::IndexWidth;

  logic                vb;
  logic signed [W+1:0] first, last;
  logic signed [W-1:0] step;
  logic signed [W-1:0] eff_step;

  assign busy     = 1'b0;
  assign eff_step = in_beat.step_given ? in_beat.step_value : W'(1);

  sin_bounds #(.W(W)) u_bounds (
    .clk, .rst_n,
    .in_vld (start),
    .len    (in_beat.seq_length),
    .a_idx  (in_beat.start_index),
    .a_given(in_beat.start_given),
    .b_idx  (in_beat.stop_index),
    .b_given(in_beat.stop_given),
    .step   (eff_step),
    .out_vld(vb),
    .first, .last,
    .step_o (step)
  );

  logic                 vs_r, ne_r;
  logic [W-1:0]         span_r, mag_r;
  sin_pkg::out_beat_t   side_r;
  logic                 fwd, zero, ne_nxt;
  logic signed [W+1:0]  span;

  assign fwd    = step > 0;
  assign zero   = step == 0;
  assign span   = fwd ? (last - first - (W+2)'(1)) : (first - last - (W+2)'(1));
  assign ne_nxt = !zero && (fwd ? (first < last) : (first > last));

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else vs_r <= vb;
  end

  always_ff @(posedge clk) begin
    ne_r   <= ne_nxt;
    span_r <= span[W-1:0];
    mag_r  <= fwd ? step : (W'(0) - step);
    side_r.norm_start      <= first[W-1:0];
    side_r.norm_stop       <= last[W-1:0];
    side_r.norm_step       <= step;
    side_r.element_count   <= '0;
    side_r.zero_step_error <= zero;
  end

  sin_divider #(.W(W)) u_div (
    .clk, .rst_n,
    .in_vld  (vs_r),
    .dividend(span_r),
    .divisor (mag_r | {{(W-1){1'b0}}, !ne_r}),
    .nonempty(ne_r),
    .side    (side_r),
    .out_vld (out_valid),
    .result  (out_beat)
  );

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.zero_step_error |-> out_beat.element_count == '0)
    else $error("zero step with nonzero count");
  a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.zero_step_error == (out_beat.norm_step == '0))
    else $error("zero step flag mismatch");
`endif

endmodule
